@@ rtl/core/v3n_pkg.sv @@
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared widths, types and constants of the vector normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package v3n_pkg;

	localparam int COMP_W   = 32;              // input component width
	localparam int OUT_W    = 32;              // result component width
	localparam int FRAC_OUT = 30;              // result fraction bits
	localparam int LANES    = 3;
	localparam int SQ_W     = 2 * COMP_W;      // square of a magnitude
	localparam int SUM_W    = 2 * COMP_W;      // 3 * 2^(2*COMP_W-2) still fits
	localparam int QUO_W    = 2 * FRAC_OUT + 1; // mag^2 * 2^60 / S <= 2^60
	localparam int ROOT_W   = FRAC_OUT + 1;    // root of the quotient <= 2^30
	localparam int RAD_W    = 2 * ROOT_W;      // radicand padded to bit pairs
	localparam int REM_W    = ROOT_W + 3;      // square root partial remainder

	typedef logic [COMP_W-1:0] mag_t;
	typedef logic [SQ_W-1:0]   sq_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [QUO_W-1:0]  quo_t;
	typedef logic [ROOT_W-1:0] root_t;
	typedef logic [RAD_W-1:0]  rad_t;
	typedef logic [REM_W-1:0]  rem_t;

	// Control that travels with each word down the pipeline.
	typedef struct packed {
		logic             valid;
		logic             zero;
		logic [LANES-1:0] neg;
	} tag_t;

	localparam root_t ONE_Q = root_t'(1) << FRAC_OUT;

endpackage

`default_nettype wire

@@ rtl/core/v3n_in_if.sv @@
// ----------------------------------------------------------------------------
// v3n_in_if
// Input channel: one three-component vector per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface v3n_in_if;
	logic                           valid;
	logic                           ready;
	logic signed [v3n_pkg::COMP_W-1:0] comp_x;
	logic signed [v3n_pkg::COMP_W-1:0] comp_y;
	logic signed [v3n_pkg::COMP_W-1:0] comp_z;

	modport source (output valid, comp_x, comp_y, comp_z, input ready);
	modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

`default_nettype wire

@@ rtl/core/v3n_out_if.sv @@
// ----------------------------------------------------------------------------
// v3n_out_if
// Output channel: one normalized vector and its zero flag per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface v3n_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [v3n_pkg::OUT_W-1:0] unit_x;
	logic signed [v3n_pkg::OUT_W-1:0] unit_y;
	logic signed [v3n_pkg::OUT_W-1:0] unit_z;
	logic                             zero_vector;

	modport source (output valid, unit_x, unit_y, unit_z, zero_vector, input ready);
	modport sink   (input valid, unit_x, unit_y, unit_z, zero_vector, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vector3_normalize.sv @@
// ----------------------------------------------------------------------------
// vector3_normalize
// Scales a signed Q16.16 three-component vector to unit length in Q2.30.
// ----------------------------------------------------------------------------
//
//  channel | role   | word contents
//  --------+--------+------------------------------------------------
//  vin     | sink   | comp_x, comp_y, comp_z (signed Q16.16)
//  vout    | source | unit_x, unit_y, unit_z (signed Q2.30), zero_vector
//
//  One word enters per cycle while vout is not stalled; each word passes the
//  square/sum stages, one divider stage per quotient bit, one square root
//  stage per root bit, and the output register.
//  Reset clears only the control tags traveling with each word and the output valid bit.
//  A stall on vout holds every stage at once; vin.ready drops only while the
//  output register is full and not being taken.
//
`default_nettype none

module vector3_normalize (
	input wire logic clk,
	input wire logic arst_n,
	v3n_in_if.sink   vin,
	v3n_out_if.source vout
);
	import v3n_pkg::*;

	logic                         en;
	tag_t                         tag_a, tag_b, tag_c;
	logic [LANES-1:0][COMP_W-1:0] comp;
	logic [LANES-1:0][SQ_W-1:0]   sq;
	sum_t                         sum;
	logic [LANES-1:0][QUO_W-1:0]  quo;
	logic [LANES-1:0][ROOT_W-1:0] root;
	logic [LANES-1:0][OUT_W-1:0]  unit_n;
	logic [LANES-1:0][OUT_W-1:0]  unit_s;
	logic                         valid_s;
	logic                         zero_s;

	// Advance the whole pipeline whenever the output register can move.
	assign en        = !valid_s || vout.ready;
	assign vin.ready = en;

	assign comp[0] = vin.comp_x;
	assign comp[1] = vin.comp_y;
	assign comp[2] = vin.comp_z;

	v3n_sqsum u_sqsum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vin.valid),
		.comp     (comp),
		.tag      (tag_a),
		.sq       (sq),
		.sum      (sum)
	);

	// Quotient floor(c^2 * 2^60 / S); its integer root is |c| * 2^30 / sqrt(S)
	// truncated, exactly.
	v3n_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_in (tag_a),
		.sq     (sq),
		.sum    (sum),
		.tag    (tag_b),
		.quo    (quo)
	);

	v3n_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_in (tag_b),
		.rad    (quo),
		.tag    (tag_c),
		.root   (root)
	);

	// Clip to one, apply sign, drop to zero for a zero vector.
	always_comb begin
		root_t mag;
		for (int k = 0; k < LANES; k++) begin
			mag = (root[k] > ONE_Q) ? ONE_Q : root[k];
			if (tag_c.zero) begin
				unit_n[k] = '0;
			end else if (tag_c.neg[k]) begin
				unit_n[k] = OUT_W'(~OUT_W'(mag) + OUT_W'(1));
			end else begin
				unit_n[k] = OUT_W'(mag);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= tag_c.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_s <= unit_n;
			zero_s <= tag_c.zero;
		end
	end

	assign vout.valid       = valid_s;
	assign vout.unit_x      = unit_s[0];
	assign vout.unit_y      = unit_s[1];
	assign vout.unit_z      = unit_s[2];
	assign vout.zero_vector = zero_s;

endmodule

`default_nettype wire

@@ rtl/core/v3n_sqsum.sv @@
// ----------------------------------------------------------------------------
// v3n_sqsum
// Magnitudes, squares and their sum, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_sqsum (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  in_valid,
	input  wire logic [v3n_pkg::LANES-1:0][v3n_pkg::COMP_W-1:0] comp,
	output      v3n_pkg::tag_t                         tag,
	output      logic [v3n_pkg::LANES-1:0][v3n_pkg::SQ_W-1:0]   sq,
	output      v3n_pkg::sum_t                         sum
);
	import v3n_pkg::*;

	tag_t                  tag_s1, tag_s2, tag_s3;
	mag_t [LANES-1:0]      mag_s1;
	sq_t  [LANES-1:0]      sq_s2, sq_s3;
	sum_t                  sum_s3;
	tag_t                  tag_in;
	mag_t [LANES-1:0]      mag_in;

	always_comb begin
		tag_in.valid = in_valid;
		tag_in.zero  = (comp == '0);
		for (int k = 0; k < LANES; k++) begin
			tag_in.neg[k] = comp[k][COMP_W-1];
			mag_in[k]     = comp[k][COMP_W-1] ? (~comp[k] + mag_t'(1)) : comp[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_in;
			for (int k = 0; k < LANES; k++) begin
				sq_s2[k] <= SQ_W'(mag_s1[k]) * SQ_W'(mag_s1[k]);
			end
			sq_s3  <= sq_s2;
			sum_s3 <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		end
	end

	assign tag = tag_s3;
	assign sq  = sq_s3;
	assign sum = sum_s3;

endmodule

`default_nettype wire

@@ rtl/core/v3n_div.sv @@
// ----------------------------------------------------------------------------
// v3n_div
// Restoring divider, one quotient bit per stage: floor(sq * 2^60 / sum).
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_div (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire v3n_pkg::tag_t                         tag_in,
	input  wire logic [v3n_pkg::LANES-1:0][v3n_pkg::SQ_W-1:0] sq,
	input  wire v3n_pkg::sum_t                         sum,
	output      v3n_pkg::tag_t                         tag,
	output      logic [v3n_pkg::LANES-1:0][v3n_pkg::QUO_W-1:0] quo
);
	import v3n_pkg::*;

	tag_t              tag_s [QUO_W];
	sum_t              dvs_s [QUO_W];
	sum_t [LANES-1:0]  rem_s [QUO_W];
	quo_t [LANES-1:0]  quo_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		tag_t             tag_p;
		sum_t             dvs_p;
		sum_t [LANES-1:0] rem_p;
		quo_t [LANES-1:0] quo_p;
		logic [LANES-1:0] bit_p;
		sum_t [LANES-1:0] rem_n;
		quo_t [LANES-1:0] quo_n;

		if (i == 0) begin : g_first
			// Bring in the top of sq * 2^60: sq >> 1, then its low bit.
			always_comb begin
				tag_p = tag_in;
				dvs_p = sum;
				for (int k = 0; k < LANES; k++) begin
					rem_p[k] = SUM_W'(sq[k] >> 1);
					bit_p[k] = sq[k][0];
					quo_p[k] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				tag_p = tag_s[i-1];
				dvs_p = dvs_s[i-1];
				rem_p = rem_s[i-1];
				quo_p = quo_s[i-1];
				bit_p = '0;
			end
		end

		always_comb begin
			logic [SUM_W:0] trial;
			for (int k = 0; k < LANES; k++) begin
				trial = {rem_p[k], bit_p[k]};
				if (trial >= {1'b0, dvs_p}) begin
					rem_n[k] = SUM_W'(trial - {1'b0, dvs_p});
					quo_n[k] = {quo_p[k][QUO_W-2:0], 1'b1};
				end else begin
					rem_n[k] = trial[SUM_W-1:0];
					quo_n[k] = {quo_p[k][QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else if (en) begin
				tag_s[i] <= tag_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[i] <= dvs_p;
				rem_s[i] <= rem_n;
				quo_s[i] <= quo_n;
			end
		end
	end

	assign tag = tag_s[QUO_W-1];
	assign quo = quo_s[QUO_W-1];

endmodule

`default_nettype wire

@@ rtl/core/v3n_sqrt.sv @@
// ----------------------------------------------------------------------------
// v3n_sqrt
// Digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_sqrt (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire v3n_pkg::tag_t                          tag_in,
	input  wire logic [v3n_pkg::LANES-1:0][v3n_pkg::QUO_W-1:0]  rad,
	output      v3n_pkg::tag_t                          tag,
	output      logic [v3n_pkg::LANES-1:0][v3n_pkg::ROOT_W-1:0] root
);
	import v3n_pkg::*;

	tag_t              tag_s  [ROOT_W];
	rad_t  [LANES-1:0] rad_s  [ROOT_W];
	rem_t  [LANES-1:0] rem_s  [ROOT_W];
	root_t [LANES-1:0] root_s [ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
		tag_t              tag_p;
		rad_t  [LANES-1:0] rad_p;
		rem_t  [LANES-1:0] rem_p;
		root_t [LANES-1:0] root_p;
		rem_t  [LANES-1:0] rem_n;
		root_t [LANES-1:0] root_n;

		if (j == 0) begin : g_first
			always_comb begin
				tag_p = tag_in;
				for (int k = 0; k < LANES; k++) begin
					rad_p[k]  = RAD_W'(rad[k]);
					rem_p[k]  = '0;
					root_p[k] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				tag_p  = tag_s[j-1];
				rad_p  = rad_s[j-1];
				rem_p  = rem_s[j-1];
				root_p = root_s[j-1];
			end
		end

		always_comb begin
			logic [REM_W+1:0] cur;
			logic [REM_W+1:0] trial;
			for (int k = 0; k < LANES; k++) begin
				cur   = {rem_p[k], rad_p[k][RAD_W-1 -: 2]};
				trial = (REM_W+2)'({root_p[k], 2'b01});
				if (cur >= trial) begin
					rem_n[k]  = REM_W'(cur - trial);
					root_n[k] = {root_p[k][ROOT_W-2:0], 1'b1};
				end else begin
					rem_n[k]  = cur[REM_W-1:0];
					root_n[k] = {root_p[k][ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[j] <= '0;
			end else if (en) begin
				tag_s[j] <= tag_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < LANES; k++) begin
					rad_s[j][k] <= rad_p[k] << 2;
				end
				rem_s[j]  <= rem_n;
				root_s[j] <= root_n;
			end
		end
	end

	assign tag  = tag_s[ROOT_W-1];
	assign root = root_s[ROOT_W-1];

endmodule

`default_nettype wire

@@ verif/vector3_normalize_chk.sv @@
// ----------------------------------------------------------------------------
// vector3_normalize_chk
// Watches both channels, predicts each unit vector and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalize_chk (
	input wire logic clk,
	input wire logic arst_n,
	v3n_in_if        vin,
	v3n_out_if       vout,
	output int       fail_count,
	output int       pending_count
);
	import v3n_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0] ux;
		logic signed [OUT_W-1:0] uy;
		logic signed [OUT_W-1:0] uz;
		logic                    zero;
	} unit_vec_t;

	unit_vec_t unit_q[$];

	// Largest q with q^2 * sum <= mag^2 * 2^60, clipped to one.
	function automatic logic [30:0] unit_mag(logic [COMP_W-1:0] mag, logic [63:0] sum);
		logic [191:0] limit_w, prod;
		logic [30:0]  q, cand;
		q = '0;
		limit_w = ({160'b0, mag} * {160'b0, mag}) << 60;
		for (int b = 30; b >= 0; b--) begin
			cand = q | (31'd1 << b);
			prod = {161'b0, cand} * {161'b0, cand} * {128'b0, sum};
			if (prod <= limit_w)
				q = cand;
		end
		if (q > (31'd1 << FRAC_OUT))
			q = 31'd1 << FRAC_OUT;
		return q;
	endfunction

	function automatic unit_vec_t normalize(logic [COMP_W-1:0] cx, logic [COMP_W-1:0] cy,
			logic [COMP_W-1:0] cz);
		logic [COMP_W-1:0] mag [3];
		logic [COMP_W-1:0] comp [3];
		logic [63:0]       sum;
		logic [OUT_W-1:0]  res [3];
		logic [30:0]       q;
		unit_vec_t         u;
		comp[0] = cx;
		comp[1] = cy;
		comp[2] = cz;
		sum = '0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = comp[k][COMP_W-1] ? -comp[k] : comp[k];
			sum += {32'b0, mag[k]} * {32'b0, mag[k]};
		end
		for (int k = 0; k < 3; k++) begin
			q = (sum == 0) ? 31'd0 : unit_mag(mag[k], sum);
			res[k] = comp[k][COMP_W-1] ? -{1'b0, q} : {1'b0, q};
		end
		u.ux = res[0];
		u.uy = res[1];
		u.uz = res[2];
		u.zero = (sum == 0);
		return u;
	endfunction

	assign pending_count = unit_q.size();

	always @(posedge clk) begin
		unit_vec_t got, want;
		if (!arst_n) begin
			fail_count = 0;
		end else begin
			if (vin.valid && vin.ready)
				unit_q.push_back(normalize(vin.comp_x, vin.comp_y, vin.comp_z));
			if (vout.valid && vout.ready) begin
				got.ux = vout.unit_x;
				got.uy = vout.unit_y;
				got.uz = vout.unit_z;
				got.zero = vout.zero_vector;
				if (unit_q.size() == 0) begin
					$error("unexpected word on vout");
					fail_count++;
				end else begin
					want = unit_q.pop_front();
					if (got.ux !== want.ux) begin
						$error("unit_x: expected %0d, got %0d", want.ux, got.ux);
						fail_count++;
					end
					if (got.uy !== want.uy) begin
						$error("unit_y: expected %0d, got %0d", want.uy, got.uy);
						fail_count++;
					end
					if (got.uz !== want.uz) begin
						$error("unit_z: expected %0d, got %0d", want.uz, got.uz);
						fail_count++;
					end
					if (got.zero !== want.zero) begin
						$error("zero_vector: expected %0b, got %0b", want.zero, got.zero);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ verif/vector3_normalize_tb.sv @@
// ----------------------------------------------------------------------------
// vector3_normalize_tb
// Drives vectors into the normalizer under random idling and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalize_tb;
	import v3n_pkg::*;

	localparam int RANDOM_WORDS = 1600;
	localparam int CALM_WORDS   = 200;    // final stretch with no idling
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 200;    // pipeline is about 96 deep
	localparam int HOLD_CYCLES  = 400;

	localparam logic [COMP_W-1:0] C_MAX = {1'b0, {(COMP_W-1){1'b1}}};
	localparam logic [COMP_W-1:0] C_MIN = {1'b1, {(COMP_W-1){1'b0}}};

	logic clk;
	logic arst_n;
	int   fail_count, pending_count;
	int   cycles;
	bit   calm;       // set for the last part: no idling on either side
	bit   hold_req;   // ask the receiver for one long hold-off

	v3n_in_if  vin();
	v3n_out_if vout();

	vector3_normalize dut (.clk(clk), .arst_n(arst_n), .vin(vin), .vout(vout));

	vector3_normalize_chk chk (
		.clk(clk), .arst_n(arst_n), .vin(vin), .vout(vout),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Give up if the run stalls.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("vector3_normalize regression: fail");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request so the
	// pipeline fills and vin.ready drops.
	initial begin
		int n;
		bit hold_done;
		hold_done  = 1'b0;
		vout.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				vout.ready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(negedge clk);
				hold_done = 1'b1;
				vout.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				vout.ready <= 1'b0;
				n = $urandom_range(1, 15);
				repeat (n) @(negedge clk);
				vout.ready <= 1'b1;
			end else begin
				vout.ready <= 1'b1;
			end
		end
	end

	// Offer one word; valid stays high until the next call or an idle gap.
	task automatic send_vec(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y, logic [COMP_W-1:0] z);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			vin.valid <= 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(negedge clk);
		end
		vin.valid  <= 1'b1;
		vin.comp_x <= x;
		vin.comp_y <= y;
		vin.comp_z <= z;
		do
			@(posedge clk);
		while (!vin.ready);
		@(negedge clk);
	endtask

	// Random component: full range, an extreme, a narrow magnitude, or zero.
	function automatic logic [COMP_W-1:0] rand_comp();
		logic [COMP_W-1:0] v;
		int sh;
		case ($urandom_range(0, 9))
			0:       v = '0;
			1:       v = $urandom_range(0, 1) ? C_MAX : C_MIN;
			2, 3, 4: begin
				sh = $urandom_range(1, COMP_W - 1);
				v = $urandom >> sh;
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	initial begin
		logic [COMP_W-1:0] x, y, z;
		calm        = 1'b0;
		hold_req    = 1'b0;
		vin.valid   = 1'b0;
		vin.comp_x  = '0;
		vin.comp_y  = '0;
		vin.comp_z  = '0;
		arst_n      = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: zero vector, each axis alone (x and z at both signs, y negative
		// only), most negative components, mixed extremes, tiny values.
		send_vec('0, '0, '0);
		send_vec(32'd1, '0, '0);
		send_vec('0, -32'sd1, '0);
		send_vec('0, '0, C_MAX);
		send_vec(C_MIN, '0, '0);
		send_vec('0, C_MIN, '0);
		send_vec('0, '0, C_MIN);
		send_vec(C_MAX, C_MAX, C_MAX);
		send_vec(C_MIN, C_MIN, C_MIN);
		send_vec(C_MIN, C_MAX, C_MIN);
		send_vec(32'd1, 32'd1, 32'd1);
		send_vec(-32'sd1, -32'sd1, -32'sd1);
		send_vec(32'd3, 32'd4, '0);
		send_vec(-32'sd2, 32'd1, -32'sd2);
		send_vec(C_MAX, 32'd1, '0);
		send_vec(32'h0001_0000, 32'h0001_0000, '0);
		send_vec('0, '0, '0);
		send_vec(32'hFFFF_FFFF, C_MAX, '0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS - CALM_WORDS)
				calm = 1'b1;
			// Hold the receiver off while words keep coming.
			if (i == 300)
				hold_req = 1'b1;
			// Pause until the block has drained.
			if (i == 800) begin
				vin.valid <= 1'b0;
				wait (pending_count == 0);
				@(negedge clk);
			end
			x = rand_comp();
			y = rand_comp();
			z = rand_comp();
			send_vec(x, y, z);
		end
		vin.valid <= 1'b0;

		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("vector3_normalize regression: pass");
		else
			$display("vector3_normalize regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
